// ----- rtl/core/spmq_pkg.sv -----
package spmq_pkg;

    // operation codes carried in the input tuser bit
    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    // result status codes carried in the output tuser
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_EMIT = 2'd2
    } state_t;

    // level taken by an enqueue whose priority is out of range
    localparam int unsigned FALLBACK_LEVEL = 2;

    // stream payload widths
    localparam int unsigned IN_VALUE_W  = 32;
    localparam int unsigned IN_PRIO_W   = 3;
    localparam int unsigned IN_DATA_W   = 40;
    localparam int unsigned OUT_LEVEL_W = 2;
    localparam int unsigned OUT_DATA_W  = 40;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/core/spmq_ctrl.sv -----
module spmq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  spmq_pkg::sts_t     sts,
    output spmq_pkg::cmd_t     cmd
);

    spmq_pkg::state_t state_reg;
    spmq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spmq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            spmq_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = spmq_pkg::S_EXEC;
                end
            end
            spmq_pkg::S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = spmq_pkg::S_EMIT;
            end
            spmq_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = spmq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spmq_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // an accepted transaction always runs its update in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (cmd.execute && !s_tready))
        else $error("accepted transaction not executed");
`endif

endmodule

// ----- rtl/core/spmq_dp.sv -----
module spmq_dp
#(
    parameter int LEVEL_COUNT = 4,
    parameter int LEVEL_DEPTH = 16,
    parameter int VALUE_BITS  = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [spmq_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [spmq_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [1:0]                        m_tuser,
    input  spmq_pkg::cmd_t                    cmd,
    output spmq_pkg::sts_t                    sts
);

    localparam int LVL_W = (LEVEL_COUNT > 4) ? $clog2(LEVEL_COUNT) : 2;
    localparam int PTR_W = $clog2(LEVEL_DEPTH);
    localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

    // captured transaction
    spmq_pkg::op_t                    op_reg;
    logic [VALUE_BITS-1:0]            value_reg;
    logic [spmq_pkg::IN_PRIO_W-1:0]   prio_reg;

    // queue bookkeeping
    logic [PTR_W-1:0] head_reg [LEVEL_COUNT];
    logic [PTR_W-1:0] tail_reg [LEVEL_COUNT];
    logic [CNT_W-1:0] cnt_reg  [LEVEL_COUNT];
    logic [CNT_W-1:0] cnt_next [LEVEL_COUNT];

    // entry storage, one row per level
    logic [VALUE_BITS-1:0] mem [LEVEL_COUNT][LEVEL_DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;

    // staged result
    spmq_pkg::status_t res_status_reg;
    logic [LVL_W-1:0]  res_level_reg;
    logic              res_empty_reg;
    logic              res_use_mem_reg;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    spmq_pkg::status_t             out_status_reg;
    logic [spmq_pkg::IN_VALUE_W-1:0] out_value_reg;
    logic [spmq_pkg::OUT_LEVEL_W-1:0] out_level_reg;
    logic                          out_empty_reg;

    logic              [LVL_W-1:0] tgt_lvl;
    logic              [LVL_W-1:0] hit_lvl;
    logic                          hit_found;
    logic                          tgt_full;
    logic                          push_en;
    logic                          pop_en;
    logic                          empty_after;
    logic              [PTR_W-1:0] tail_adv;
    logic              [PTR_W-1:0] head_adv;
    spmq_pkg::status_t             res_status;
    logic              [LVL_W-1:0] res_level;
    logic signed       [63:0]      value_ext;
    logic              [63:0]      rd_wide;

    assign value_ext = 64'(signed'(s_tdata[spmq_pkg::IN_VALUE_W-1:0]));
    assign rd_wide   = 64'(rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= spmq_pkg::op_t'(s_tuser);
            value_reg <= value_ext[VALUE_BITS-1:0];
            prio_reg  <= s_tdata[spmq_pkg::IN_VALUE_W +: spmq_pkg::IN_PRIO_W];
        end
    end

    always_comb
    begin
        // out-of-range priority falls back to the normal level
        if (int'(prio_reg) < LEVEL_COUNT)
        begin
            tgt_lvl = LVL_W'(prio_reg);
        end
        else
        begin
            tgt_lvl = LVL_W'(spmq_pkg::FALLBACK_LEVEL);
        end

        // most urgent non-empty level
        hit_found = 1'b0;
        hit_lvl   = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0)
            begin
                hit_found = 1'b1;
                hit_lvl   = LVL_W'(i);
            end
        end

        tgt_full = (cnt_reg[tgt_lvl] == CNT_W'(LEVEL_DEPTH));
        push_en  = cmd.execute && (op_reg == spmq_pkg::OP_ENQ) && !tgt_full;
        pop_en   = cmd.execute && (op_reg == spmq_pkg::OP_DEQ) && hit_found;

        tail_adv = (tail_reg[tgt_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                                                                 : tail_reg[tgt_lvl] + 1'b1;
        head_adv = (head_reg[hit_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                                                                 : head_reg[hit_lvl] + 1'b1;

        empty_after = 1'b1;
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (push_en && (tgt_lvl == LVL_W'(i)))
            begin
                cnt_next[i] = cnt_reg[i] + 1'b1;
            end
            if (pop_en && (hit_lvl == LVL_W'(i)))
            begin
                cnt_next[i] = cnt_reg[i] - 1'b1;
            end
            if (cnt_next[i] != '0)
            begin
                empty_after = 1'b0;
            end
        end

        if (op_reg == spmq_pkg::OP_ENQ)
        begin
            res_level  = tgt_lvl;
            res_status = tgt_full ? spmq_pkg::ST_FULL : spmq_pkg::ST_DONE;
        end
        else if (hit_found)
        begin
            res_level  = hit_lvl;
            res_status = spmq_pkg::ST_DONE;
        end
        else
        begin
            res_level  = '0;
            res_status = spmq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            if (push_en)
            begin
                tail_reg[tgt_lvl] <= tail_adv;
            end
            if (pop_en)
            begin
                head_reg[hit_lvl] <= head_adv;
            end
        end
    end

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[tgt_lvl][tail_reg[tgt_lvl]] <= value_reg;
        end
        if (pop_en)
        begin
            rd_data_reg <= mem[hit_lvl][head_reg[hit_lvl]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            res_status_reg  <= res_status;
            res_level_reg   <= res_level;
            res_empty_reg   <= empty_after;
            res_use_mem_reg <= pop_en;
        end
    end

    // output register
    assign sts.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_use_mem_reg ? rd_wide[spmq_pkg::IN_VALUE_W-1:0] : '0;
            out_level_reg  <= res_level_reg[spmq_pkg::OUT_LEVEL_W-1:0];
            out_empty_reg  <= res_empty_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'd0, out_empty_reg, out_level_reg, out_value_reg};

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> (cnt_reg[tgt_lvl] != CNT_W'(LEVEL_DEPTH)))
        else $error("push into a full level");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop_en |-> (cnt_reg[hit_lvl] != '0))
        else $error("pop from an empty level");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop_en |=> (cnt_reg[$past(hit_lvl)] == $past(cnt_reg[hit_lvl]) - 1'b1))
        else $error("level count not decremented after pop");
`endif

endmodule

// ----- rtl/core/strict_priority_multi_queue.sv -----
// strict priority multi-level fifo: one transaction at a time, with no new input accepted
// until the previous result is loaded into the output register; each transaction passes
// through capture, queue update with registered storage read and output load, and the
//   output load waits while the output register holds a result not yet taken
// reset: rst_n asynchronous active low clears pointers, level counts and handshake state;
//   the entry storage is not cleared and needs no clearing pass
module strict_priority_multi_queue
#(
    parameter int LEVEL_COUNT = 4,
    parameter int LEVEL_DEPTH = 16,
    parameter int VALUE_BITS  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value_in[31:0], priority_in[34:32], zero pad[39:35]
    input  logic        s_tuser,   // operation[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value_out[31:0], served_level[33:32], all_empty[34], pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    // command and status between sequencer and datapath
    spmq_pkg::cmd_t cmd;
    spmq_pkg::sts_t sts;

    // sequencer: idle -> update -> result load
    spmq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: per-level pointers and counts, entry storage, output register
    spmq_dp
    #(
        .LEVEL_COUNT (LEVEL_COUNT),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
